/* rtl/pca_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Palette color allocator package
// Shared constants, register indexes and the search token carried by the
// chain of palette cells.
// ----------------------------------------------------------------------------
package pca_pkg;

  // Number of palette entries, one cell per entry.
  localparam int PALETTE_DEPTH = 256;

  // Entry position and used count widths.
  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

  // Fixed field widths.
  localparam int COMP_W  = 8;
  localparam int KEY_W   = 3 * COMP_W;
  localparam int INDEX_W = 8;
  localparam int PROD_W  = 2 * COMP_W;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam logic [COMP_W-1:0] COMPONENT_FULL = 8'd255;

  localparam logic [CFG_ADDR_W-1:0] REG_NATIVE_MAX_RED   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NATIVE_MAX_GREEN = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NATIVE_MAX_BLUE  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_MAX_RED   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_MAX_GREEN = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_MAX_BLUE  = 3'd5;

  // Search token that walks down the cell chain, one cell per cycle.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] pos;
    logic             hit;
    logic [IDX_W-1:0] hit_pos;
    logic             alloc;
  } token_t;

endpackage
`default_nettype wire

/* rtl/pca_pixel_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Palette color allocator input channel
// Valid/ready channel carrying one external RGB color per item.
// ----------------------------------------------------------------------------
interface pca_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [pca_pkg::COMP_W-1:0] in_red;
  logic [pca_pkg::COMP_W-1:0] in_green;
  logic [pca_pkg::COMP_W-1:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue,
                output ready);
endinterface
`default_nettype wire

/* rtl/pca_result_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Palette color allocator result channel
// Valid/ready channel carrying one palette index result per item.
// ----------------------------------------------------------------------------
interface pca_result_if;
  logic                        valid;
  logic                        ready;
  logic [pca_pkg::INDEX_W-1:0] color_index;
  logic                        was_found;
  logic                        full_overflow;

  modport source (output valid, output color_index, output was_found,
                  output full_overflow, input ready);
  modport sink (input valid, input color_index, input was_found,
                input full_overflow, output ready);
endinterface
`default_nettype wire

/* rtl/palette_color_allocator.sv */
`default_nettype none
// From accept to result valid an item passes the multiply and the bit-serial
// divider, the injection register, the chain of cells and the decode and output registers.
// One item is in flight at a time; the next is accepted only once the previous result
// has been registered, and later while an earlier result still waits for ready.
// Reset clears the used count, control and the configuration (all 255);
// palette entries hold no reset value and are read only after being written.
// ----------------------------------------------------------------------------
// Palette color allocator
// Rescales an RGB color, then walks a chain of palette cells to find an exact
// match or append the color, returning the palette index or, when full, an overflow flag.
// ----------------------------------------------------------------------------
module palette_color_allocator (
  input  wire logic                           clk,
  input  wire logic                           rst,
  pca_pixel_if.sink                           pixel,
  pca_result_if.source                        result,
  input  wire logic                           cfg_we,
  input  wire logic [pca_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  wire logic [pca_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCALE  = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_REPLY  = 2'd3;

  logic [1:0] state;

  logic [pca_pkg::COMP_W-1:0] native_max_red;
  logic [pca_pkg::COMP_W-1:0] native_max_green;
  logic [pca_pkg::COMP_W-1:0] native_max_blue;
  logic [pca_pkg::COMP_W-1:0] source_max_red;
  logic [pca_pkg::COMP_W-1:0] source_max_green;
  logic [pca_pkg::COMP_W-1:0] source_max_blue;

  logic [pca_pkg::CNT_W-1:0]  used_count;
  logic                       accept;
  logic                       done_red;
  logic                       done_green;
  logic                       done_blue;
  logic [pca_pkg::COMP_W-1:0] scaled_red;
  logic [pca_pkg::COMP_W-1:0] scaled_green;
  logic [pca_pkg::COMP_W-1:0] scaled_blue;

  pca_pkg::token_t inj;
  pca_pkg::token_t chain [pca_pkg::PALETTE_DEPTH+1];
  pca_pkg::token_t tail;

  logic [pca_pkg::INDEX_W-1:0] hold_index;
  logic                        hold_found;
  logic                        hold_ovf;
  logic                        res_valid;
  logic [pca_pkg::INDEX_W-1:0] res_index;
  logic                        res_found;
  logic                        res_ovf;

  assign accept      = pixel.valid && pixel.ready;
  assign pixel.ready = (state == ST_IDLE);

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      native_max_red   <= pca_pkg::COMPONENT_FULL;
      native_max_green <= pca_pkg::COMPONENT_FULL;
      native_max_blue  <= pca_pkg::COMPONENT_FULL;
      source_max_red   <= pca_pkg::COMPONENT_FULL;
      source_max_green <= pca_pkg::COMPONENT_FULL;
      source_max_blue  <= pca_pkg::COMPONENT_FULL;
    end else if (cfg_we) begin
      case (cfg_index)
        pca_pkg::REG_NATIVE_MAX_RED:   native_max_red   <= cfg_wdata;
        pca_pkg::REG_NATIVE_MAX_GREEN: native_max_green <= cfg_wdata;
        pca_pkg::REG_NATIVE_MAX_BLUE:  native_max_blue  <= cfg_wdata;
        pca_pkg::REG_SOURCE_MAX_RED:   source_max_red   <= cfg_wdata;
        pca_pkg::REG_SOURCE_MAX_GREEN: source_max_green <= cfg_wdata;
        pca_pkg::REG_SOURCE_MAX_BLUE:  source_max_blue  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Component rescalers, started together on the accepted item.
  pca_rescale u_scale_red (
    .clk(clk), .rst(rst), .start(accept), .value(pixel.in_red),
    .nmax(native_max_red), .smax(source_max_red),
    .done(done_red), .result(scaled_red)
  );

  pca_rescale u_scale_green (
    .clk(clk), .rst(rst), .start(accept), .value(pixel.in_green),
    .nmax(native_max_green), .smax(source_max_green),
    .done(done_green), .result(scaled_green)
  );

  pca_rescale u_scale_blue (
    .clk(clk), .rst(rst), .start(accept), .value(pixel.in_blue),
    .nmax(native_max_blue), .smax(source_max_blue),
    .done(done_blue), .result(scaled_blue)
  );

  // Token injection into the head of the cell chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      inj.valid <= 1'b0;
    end else begin
      inj.valid <= (state == ST_SCALE) && done_red && done_green && done_blue;
    end
    inj.key     <= {scaled_red, scaled_green, scaled_blue};
    inj.pos     <= '0;
    inj.hit     <= 1'b0;
    inj.hit_pos <= '0;
    inj.alloc   <= 1'b0;
  end

  assign chain[0] = inj;

  // Row of palette cells, one per entry.
  for (genvar g = 0; g < pca_pkg::PALETTE_DEPTH; g++) begin : g_cell
    pca_cell u_cell (
      .clk(clk),
      .rst(rst),
      .used_count(used_count),
      .tok_in(chain[g]),
      .tok_out(chain[g+1])
    );
  end

  assign tail = chain[pca_pkg::PALETTE_DEPTH];

  // Sequencer, used count and result hold.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used_count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (done_red && done_green && done_blue) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (tail.valid) begin
            state <= ST_REPLY;
            if (tail.alloc) begin
              used_count <= used_count + 1'b1;
            end
          end
        end
        ST_REPLY: begin
          if (!res_valid || result.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Decode the token leaving the chain into the result fields.
  always_ff @(posedge clk) begin
    if ((state == ST_SEARCH) && tail.valid) begin
      hold_found <= tail.hit;
      hold_ovf   <= !tail.hit && !tail.alloc;
      if (tail.hit) begin
        hold_index <= pca_pkg::INDEX_W'(tail.hit_pos);
      end else if (tail.alloc) begin
        hold_index <= pca_pkg::INDEX_W'(used_count[pca_pkg::IDX_W-1:0]);
      end else begin
        hold_index <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == ST_REPLY) && (!res_valid || result.ready)) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if ((state == ST_REPLY) && (!res_valid || result.ready)) begin
      res_index <= hold_index;
      res_found <= hold_found;
      res_ovf   <= hold_ovf;
    end
  end

  assign result.valid         = res_valid;
  assign result.color_index   = res_index;
  assign result.was_found     = res_found;
  assign result.full_overflow = res_ovf;

endmodule
`default_nettype wire

/* rtl/pca_rescale.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Palette color allocator component rescaler
// Computes min(value * nmax / smax, nmax) with a registered multiply and a
// restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pca_rescale (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [pca_pkg::COMP_W-1:0] value,
  input  wire logic [pca_pkg::COMP_W-1:0] nmax,
  input  wire logic [pca_pkg::COMP_W-1:0] smax,
  output logic                            done,
  output logic [pca_pkg::COMP_W-1:0]      result
);

  localparam int STEP_W = $clog2(pca_pkg::PROD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(pca_pkg::PROD_W - 1);

  logic                        busy;
  logic [STEP_W-1:0]           step;
  logic [pca_pkg::PROD_W-1:0]  quo;
  logic [pca_pkg::COMP_W-1:0]  rem;
  logic [pca_pkg::COMP_W:0]    trial;
  logic                        ge;
  logic [pca_pkg::COMP_W:0]    diff;

  // One restoring division step: shift in the next dividend bit and subtract.
  always_comb begin
    trial = {rem, quo[pca_pkg::PROD_W-1]};
    ge    = trial >= {1'b0, smax};
    diff  = trial - {1'b0, smax};
  end

  // Control: start loads the product, then one step per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: the dividend register turns into the quotient bit by bit.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= pca_pkg::PROD_W'(value) * pca_pkg::PROD_W'(nmax);
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[pca_pkg::PROD_W-2:0], ge};
      rem <= ge ? diff[pca_pkg::COMP_W-1:0] : trial[pca_pkg::COMP_W-1:0];
    end
  end

  // Saturate to the native maximum; a zero source maximum saturates too.
  always_comb begin
    if ((smax == '0) || (quo > {{pca_pkg::COMP_W{1'b0}}, nmax})) begin
      result = nmax;
    end else begin
      result = quo[pca_pkg::COMP_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/pca_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Palette color allocator cell
// Holds one palette entry. Compares the passing token against the entry,
// claims the entry for a new color at the append position, and hands the
// token to the next cell through its output register.
// ----------------------------------------------------------------------------
module pca_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [pca_pkg::CNT_W-1:0]  used_count,
  input  wire pca_pkg::token_t            tok_in,
  output pca_pkg::token_t                 tok_out
);

  logic [pca_pkg::KEY_W-1:0] entry;
  logic [pca_pkg::CNT_W-1:0] pos_wide;
  logic                      match;
  logic                      append;

  // Only entries below the used count take part in the search; the first
  // free position takes the color when nothing matched.
  always_comb begin
    pos_wide = pca_pkg::CNT_W'(tok_in.pos);
    match    = tok_in.valid && !tok_in.hit && (pos_wide < used_count) &&
               (entry == tok_in.key);
    append   = tok_in.valid && !tok_in.hit && (pos_wide == used_count);
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (append) begin
      entry <= tok_in.key;
    end
  end

  // Token hand-off to the neighbor.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.key     <= tok_in.key;
    tok_out.pos     <= tok_in.pos + 1'b1;
    tok_out.hit     <= tok_in.hit || match;
    tok_out.hit_pos <= match ? tok_in.pos : tok_in.hit_pos;
    tok_out.alloc   <= tok_in.alloc || append;
  end

endmodule
`default_nettype wire
